>>> rtl/fbs_pkg.sv
// Shared types and constants for the bounded queue with membership search.
`default_nettype none
package fbs_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int DATA_BITS_DEFAULT = 32;

   localparam int CMD_W   = 2;
   localparam int VALUE_W = 32;
   localparam int CAP_W   = 5;
   localparam int OCC_W   = 5;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [CMD_W-1:0] CMD_PUSH     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP      = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP      = 2'd3;

   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_INIT     = 1'b1;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   // Per-cycle control broadcast to every cell of the chain.
   typedef struct packed {
      logic push;   // write the pushed value into the cell at the tail
      logic shift;  // every cell takes its upper neighbor's value, the last cell zero
      logic load;   // head cell takes the initial value
   } cell_ctl_type;

endpackage
`default_nettype wire

>>> rtl/fbs_cell.sv
// One storage cell of the queue chain: holds a value, shifts toward the head, compares.
`default_nettype none
module fbs_cell #(
   parameter int DATA_BITS = fbs_pkg::DATA_BITS_DEFAULT,
   parameter int CNT_W     = 5,
   parameter int IDX       = 0
) (
   input  wire                        clock,
   input  wire fbs_pkg::cell_ctl_type ctl,
   input  wire  [CNT_W-1:0]           count,
   input  wire  [DATA_BITS-1:0]       key,
   input  wire  [DATA_BITS-1:0]       init_data,
   input  wire  [DATA_BITS-1:0]       next_data,
   output logic [DATA_BITS-1:0]       data,
   output logic                       match
);

   logic [DATA_BITS-1:0] data_ff;
   logic [DATA_BITS-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      priority if (ctl.load) begin
         if (IDX == 0) data_in = init_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end else if (ctl.push && (count == CNT_W'(IDX))) begin
         data_in = key;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign match = (CNT_W'(IDX) < count) && (data_ff == key);

endmodule
`default_nettype wire

>>> rtl/bounded_fifo_with_search_unit.sv
// Top level: bounded queue built as a shifting chain of cells, with APB-style registers.
// Results are registered: a result appears in the output register in the cycle after its command is accepted.
// Throughput: one command per cycle while the result output is not held by back-pressure; the cell chain updates in
// the accepting cycle and a contains query compares all cells at once against the key.
// Reset: synchronous; capacity returns to 16, initial value to zero, and the queue holds
// one zero entry. Any register write also brings the queue back to one entry.
`default_nettype none
module bounded_fifo_with_search_unit #(
   parameter int DEPTH     = fbs_pkg::DEPTH_DEFAULT,
   parameter int DATA_BITS = fbs_pkg::DATA_BITS_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [31:0]                  req_tdata,   // value
   input  wire  [fbs_pkg::CMD_W-1:0]    req_tuser,   // cmd
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // pop_data[31:0], found[32], overflow[33], underflow[34], occupancy[39:35]
   output logic [39:0]                  rsp_tdata,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [fbs_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire  [fbs_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [fbs_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DW    = fbs_pkg::VALUE_W;

   // Configuration registers.
   logic [fbs_pkg::CAP_W-1:0] cap_ff;
   logic [fbs_pkg::CAP_W-1:0] cap_in;
   logic [DW-1:0]             init_ff;
   logic [DW-1:0]             init_in;
   logic                      csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cap_in  = cap_ff;
      init_in = init_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == fbs_pkg::REG_CAPACITY) cap_in = csr_pwdata[fbs_pkg::CAP_W-1:0];
         else init_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= fbs_pkg::CAPACITY_RESET;
         init_ff <= '0;
      end else begin
         cap_ff  <= cap_in;
         init_ff <= init_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == fbs_pkg::REG_INIT) ? init_ff
                                                          : 32'(cap_ff);

   // Capacity clamped into 1..DEPTH.
   logic [31:0]      cap_wide;
   logic [CNT_W-1:0] limit;

   assign cap_wide = 32'(cap_ff);
   always_comb begin
      if (cap_wide == 32'd0)          limit = CNT_W'(1);
      else if (cap_wide > 32'(DEPTH)) limit = CNT_W'(DEPTH);
      else                            limit = CNT_W'(cap_wide);
   end

   // Command decode and queue control.
   logic                  req_fire;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [DATA_BITS-1:0]  key;
   logic [DATA_BITS-1:0]  init_data;
   logic                  do_push;
   logic                  do_pop;
   logic                  is_push;
   logic                  is_pop;
   logic                  is_find;
   fbs_pkg::cell_ctl_type ctl;

   assign req_tready = !rsp_tvalid || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign key       = DATA_BITS'(req_tdata);
   assign init_data = reset ? '0 : DATA_BITS'(init_in);

   assign is_push = req_fire && (req_tuser == fbs_pkg::CMD_PUSH);
   assign is_pop  = req_fire && (req_tuser == fbs_pkg::CMD_POP);
   assign is_find = req_fire && (req_tuser == fbs_pkg::CMD_CONTAINS);
   assign do_push = is_push && (count_ff < limit);
   assign do_pop  = is_pop && (count_ff > CNT_W'(1));

   // Reset and register writes reload the head cell from the initial value.
   assign ctl.load  = reset || csr_wr;
   assign ctl.shift = do_pop;
   assign ctl.push  = do_push;

   always_comb begin
      count_in = count_ff;
      priority if (csr_wr) count_in = CNT_W'(1);
      else if (do_push)    count_in = count_ff + CNT_W'(1);
      else if (do_pop)     count_in = count_ff - CNT_W'(1);
      else                 count_in = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= CNT_W'(1);
      else       count_ff <= count_in;
   end

   // Cell chain: cell 0 is the head, cells shift toward it on a pop.
   logic [DATA_BITS-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]     cell_match;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_BITS-1:0] next_data;
      if (i == DEPTH - 1) begin : g_tail
         assign next_data = '0;
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end
      fbs_cell #(
         .DATA_BITS (DATA_BITS),
         .CNT_W     (CNT_W),
         .IDX       (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .count     (count_ff),
         .key       (key),
         .init_data (init_data),
         .next_data (next_data),
         .data      (cell_data[i]),
         .match     (cell_match[i])
      );
   end

   // Result register.
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [39:0] rsp_data_ff;
   logic [39:0] rsp_data_in;
   logic [31:0] pop_data;

   assign pop_data = is_pop ? 32'(cell_data[0]) : 32'd0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire)        rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (req_fire) begin
         rsp_data_in = {fbs_pkg::OCC_W'(count_in),
                        is_pop && !do_pop,
                        is_push && !do_push,
                        is_find && (|cell_match),
                        pop_data};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The queue never empties and never exceeds its storage.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= CNT_W'(DEPTH)))
      else $error("entry count out of range");

   // A dropped push leaves the count at or above the clamped capacity.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      is_push && !do_push |-> count_ff >= limit)
      else $error("push dropped while space remained");

   // An underflow result always reports a single held entry.
   a_underflow_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34] |-> rsp_tdata[39:35] == fbs_pkg::OCC_W'(1))
      else $error("underflow with more than one entry");

   // At most one status flag per result.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[34:32]))
      else $error("conflicting status flags");

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the bounded queue with membership search unit.
`default_nettype none
module tb;

   localparam int SLOT_COUNT  = fbs_pkg::DEPTH_DEFAULT;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 80;

   // Result layout, lowest bits last in the declaration.
   typedef struct packed {
      logic [fbs_pkg::OCC_W-1:0]   occupancy;
      logic                        underflow;
      logic                        overflow;
      logic                        found;
      logic [fbs_pkg::VALUE_W-1:0] pop_data;
   } rsp_fields_type;

   // Mirror of the queue contents plus the results still owed by the block.
   class fifo_tracker;
      logic [fbs_pkg::VALUE_W-1:0] slots [SLOT_COUNT];
      int unsigned                 head;
      int unsigned                 count;
      logic [fbs_pkg::CAP_W-1:0]   capacity;
      logic [fbs_pkg::VALUE_W-1:0] init_value;
      rsp_fields_type              owed_results [$];
      int                          failures;

      function new();
         capacity   = fbs_pkg::CAPACITY_RESET;
         init_value = '0;
         failures   = 0;
         refill();
      endfunction

      function void refill();
         foreach (slots[i]) slots[i] = '0;
         slots[0] = init_value;
         head     = 0;
         count    = 1;
      endfunction

      function void write_register(logic idx, logic [fbs_pkg::CSR_DW-1:0] data);
         if (idx == fbs_pkg::REG_CAPACITY) begin
            capacity = data[fbs_pkg::CAP_W-1:0];
         end else begin
            init_value = data[fbs_pkg::VALUE_W-1:0];
         end
         refill();
      endfunction

      function int unsigned entry_limit();
         int unsigned lim;
         lim = capacity;
         if (lim < 1) lim = 1;
         if (lim > SLOT_COUNT) lim = SLOT_COUNT;
         return lim;
      endfunction

      function void predict_command(logic [fbs_pkg::CMD_W-1:0] cmd,
                                    logic [fbs_pkg::VALUE_W-1:0] value);
         rsp_fields_type want;
         want = '0;
         case (cmd)
            fbs_pkg::CMD_PUSH: begin
               if (count < entry_limit()) begin
                  slots[(head + count) % SLOT_COUNT] = value;
                  count++;
               end else begin
                  want.overflow = 1'b1;
               end
            end
            fbs_pkg::CMD_POP: begin
               want.pop_data = slots[head];
               if (count > 1) begin
                  head = (head + 1) % SLOT_COUNT;
                  count--;
               end else begin
                  want.underflow = 1'b1;
               end
            end
            fbs_pkg::CMD_CONTAINS: begin
               for (int unsigned i = 0; i < count; i++) begin
                  if (slots[(head + i) % SLOT_COUNT] == value) want.found = 1'b1;
               end
            end
            default: ;
         endcase
         want.occupancy = count[fbs_pkg::OCC_W-1:0];
         owed_results.push_back(want);
      endfunction

      function void check_result(logic [39:0] raw);
         rsp_fields_type got;
         rsp_fields_type want;
         got = raw;
         if (owed_results.size() == 0) begin
            failures++;
            if (failures <= 10) $display("ERROR: result %h arrived with no command pending", raw);
            return;
         end
         want = owed_results.pop_front();
         if (got.pop_data !== want.pop_data || got.found !== want.found ||
             got.overflow !== want.overflow || got.underflow !== want.underflow ||
             got.occupancy !== want.occupancy) begin
            failures++;
            if (failures <= 10) begin
               $display("ERROR: expected pop_data=%h found=%b ovf=%b unf=%b occ=%0d",
                        want.pop_data, want.found, want.overflow, want.underflow,
                        want.occupancy);
               $display("       actual   pop_data=%h found=%b ovf=%b unf=%b occ=%0d",
                        got.pop_data, got.found, got.overflow, got.underflow,
                        got.occupancy);
            end
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [31:0]                  req_tdata;
   logic [fbs_pkg::CMD_W-1:0]    req_tuser;
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [39:0]                  rsp_tdata;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [fbs_pkg::CSR_AW-1:0]   csr_paddr;
   logic [fbs_pkg::CSR_DW-1:0]   csr_pwdata;
   logic [fbs_pkg::CSR_DW-1:0]   csr_prdata;
   logic                         csr_pready;

   fifo_tracker tracker = new();
   int          sender_idle_pct   = 0;
   int          receiver_idle_pct = 0;
   bit          hold_ask          = 1'b0;
   int          hold_left         = 0;
   int          stall_count       = 0;

   bounded_fifo_with_search_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Receiver: random back-pressure, plus a long hold-off when one is requested.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ask) begin
            hold_ask  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_result(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   task automatic send_command(logic [fbs_pkg::CMD_W-1:0] cmd,
                               logic [fbs_pkg::VALUE_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = value;
      do @(posedge clock); while (!req_tready);
      tracker.predict_command(cmd, value);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (tracker.owed_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic idx, logic [fbs_pkg::CSR_DW-1:0] data);
      wait_drained();
      repeat (2) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.write_register(idx, data);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   function automatic logic [fbs_pkg::CMD_W-1:0] pick_command(int push_pct);
      int r;
      r = $urandom_range(99);
      if (r < push_pct) return fbs_pkg::CMD_PUSH;
      if (r < 80) return fbs_pkg::CMD_POP;
      if (r < 97) return fbs_pkg::CMD_CONTAINS;
      return fbs_pkg::CMD_NOP;
   endfunction

   // Mix of full-range values, values that may sit in the queue, and small keys.
   function automatic logic [fbs_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(3))
         0, 1: return $urandom;
         2: return tracker.slots[$urandom_range(SLOT_COUNT - 1)];
         default: return $urandom_range(1) ? $urandom_range(7) : -$urandom_range(7);
      endcase
   endfunction

   initial begin
      int unsigned caps [8];
      int          item_no;
      int          push_pct;
      int          run_left;
      logic [fbs_pkg::VALUE_W-1:0] init_val;

      caps        = '{16, 1, 4, 31, 0, 9, 16, 2};
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = fbs_pkg::CMD_NOP;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part on the reset configuration.
      send_command(fbs_pkg::CMD_CONTAINS, 32'h0000_0000);
      send_command(fbs_pkg::CMD_POP,      32'hFFFF_FFFF);
      send_command(fbs_pkg::CMD_NOP,      32'hFFFF_FFFF);
      send_command(fbs_pkg::CMD_PUSH,     32'h7FFF_FFFF);
      send_command(fbs_pkg::CMD_PUSH,     32'h8000_0000);
      send_command(fbs_pkg::CMD_PUSH,     32'hFFFF_FFFF);
      send_command(fbs_pkg::CMD_CONTAINS, 32'h8000_0000);
      send_command(fbs_pkg::CMD_CONTAINS, 32'h1234_5678);
      send_command(fbs_pkg::CMD_POP,      32'h0000_0000);
      send_command(fbs_pkg::CMD_POP,      32'h0000_0000);
      // Small capacity: overflow on a full queue, underflow on the last entry.
      write_register(fbs_pkg::REG_CAPACITY, 32'd2);
      write_register(fbs_pkg::REG_INIT, 32'h8000_0000);
      send_command(fbs_pkg::CMD_PUSH,     32'h5555_5555);
      send_command(fbs_pkg::CMD_PUSH,     32'hAAAA_AAAA);
      send_command(fbs_pkg::CMD_CONTAINS, 32'hAAAA_AAAA);
      send_command(fbs_pkg::CMD_POP,      32'h0000_0000);
      send_command(fbs_pkg::CMD_POP,      32'h0000_0000);
      send_command(fbs_pkg::CMD_POP,      32'h0000_0000);
      // A capacity of zero behaves as one.
      write_register(fbs_pkg::REG_CAPACITY, 32'd0);
      write_register(fbs_pkg::REG_INIT, 32'h7FFF_FFFF);
      send_command(fbs_pkg::CMD_PUSH,     32'h0000_0001);
      send_command(fbs_pkg::CMD_CONTAINS, 32'h7FFF_FFFF);
      send_command(fbs_pkg::CMD_POP,      32'h0000_0000);

      // Random part: several settings, push-heavy and pop-heavy runs alternate.
      item_no = 0;
      foreach (caps[s]) begin
         case (s)
            1: init_val = 32'h8000_0000;
            3: init_val = 32'h7FFF_FFFF;
            5: init_val = 32'h0000_0000;
            default: init_val = $urandom;
         endcase
         write_register(fbs_pkg::REG_CAPACITY, caps[s]);
         write_register(fbs_pkg::REG_INIT, init_val);
         push_pct = 65;
         run_left = $urandom_range(8, 30);
         for (int k = 0; k < 50; k++) begin
            if (item_no < 133) begin
               sender_idle_pct   = 33;
               receiver_idle_pct = 52;
            end else if (item_no < 266) begin
               sender_idle_pct   = 52;
               receiver_idle_pct = 33;
            end else begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
            if (s == 6 && k == 10) hold_ask = 1'b1;
            if (s == 3 && k == 25) wait_drained();
            if (run_left == 0) begin
               push_pct = (push_pct == 65) ? 20 : 65;
               run_left = $urandom_range(8, 30);
            end
            run_left--;
            send_command(pick_command(push_pct), pick_value());
            item_no++;
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (tracker.failures == 0 && tracker.owed_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
